// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define R2P_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("r2p: assertion failed");
// checked in reset too
`define R2P_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("r2p: assertion failed");
`else
`define R2P_ASSERT(lbl, prop)
`define R2P_ASSERT_RST(lbl, prop)
`endif
`endif

// File: hw/rtl/r2p_pkg.sv
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared types, widths and the arctangent table of the polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package r2p_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int GUARD_BITS   = 24;
	localparam int ATAN_ENTRIES = 24;
	localparam int XW           = SAMPLE_BITS + GUARD_BITS + 3; // CORDIC x/y, with gain headroom
	localparam int ZW           = 34;                           // angle acc, 2^31 = pi
	localparam int SW           = 2 * SAMPLE_BITS;              // sum of squares
	localparam int RW           = SAMPLE_BITS + 2;              // root remainder
	localparam int ANGLE_SHIFT  = 32 - SAMPLE_BITS;

	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1 <<< 30);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] real_part;
		logic signed [SAMPLE_BITS-1:0] imag_part;
		logic                          last_in;
	} req_t;

	typedef struct packed {
		logic        [SAMPLE_BITS-1:0] magnitude;
		logic signed [SAMPLE_BITS-1:0] angle;
		logic                          last_out;
	} rsp_t;

	// state carried down the iteration chain
	typedef struct packed {
		logic signed [XW-1:0]          x;
		logic signed [XW-1:0]          y;
		logic signed [ZW-1:0]          z;
		logic        [SW-1:0]          s;
		logic        [RW-1:0]          rem;
		logic        [SAMPLE_BITS-1:0] root;
		logic                          zero;
		logic                          last;
	} stage_t;

	// atan(2^-k), 2^31 = pi
	function automatic logic signed [ZW-1:0] atan_of(input int k);
		logic signed [ZW-1:0] v;
		case (k)
			0:  v = ZW'(536870912);
			1:  v = ZW'(316933406);
			2:  v = ZW'(167458907);
			3:  v = ZW'(85004756);
			4:  v = ZW'(42667331);
			5:  v = ZW'(21354465);
			6:  v = ZW'(10679838);
			7:  v = ZW'(5340245);
			8:  v = ZW'(2670163);
			9:  v = ZW'(1335087);
			10: v = ZW'(667544);
			11: v = ZW'(333772);
			12: v = ZW'(166886);
			13: v = ZW'(83443);
			14: v = ZW'(41722);
			15: v = ZW'(20861);
			16: v = ZW'(10430);
			17: v = ZW'(5215);
			18: v = ZW'(2608);
			19: v = ZW'(1304);
			20: v = ZW'(652);
			21: v = ZW'(326);
			22: v = ZW'(163);
			23: v = ZW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/r2p_front.sv
// ----------------------------------------------------------------------------
// r2p_front
// Two entry stages: squares and quadrant fold, then the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module r2p_front import r2p_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire req_t   req,
	output logic        out_valid,
	output stage_t      out_stage
);

	logic signed [XW-1:0] xe, ye, x_f, y_f;
	logic signed [ZW-1:0] z_f;

	logic                 vld_s1;
	logic signed [SW-1:0] sq_re_s1, sq_im_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic                 zero_s1, last_s1;

	logic                 vld_s2;
	stage_t               stage_s2;

	// fold left half-plane into the right by a quarter turn
	always_comb begin
		xe  = XW'(req.real_part) <<< GUARD_BITS;
		ye  = XW'(req.imag_part) <<< GUARD_BITS;
		x_f = xe;
		y_f = ye;
		z_f = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				x_f = ye;
				y_f = -xe;
				z_f = QUARTER_TURN;
			end else begin
				x_f = -ye;
				y_f = xe;
				z_f = -QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_re_s1 <= req.real_part * req.real_part;
		sq_im_s1 <= req.imag_part * req.imag_part;
		x_s1     <= x_f;
		y_s1     <= y_f;
		z_s1     <= z_f;
		zero_s1  <= (req.real_part == '0) && (req.imag_part == '0);
		last_s1  <= req.last_in;
	end

	always_ff @(posedge clk) begin
		stage_s2.x    <= x_s1;
		stage_s2.y    <= y_s1;
		stage_s2.z    <= z_s1;
		stage_s2.s    <= $unsigned(sq_re_s1) + $unsigned(sq_im_s1);
		stage_s2.rem  <= '0;
		stage_s2.root <= '0;
		stage_s2.zero <= zero_s1;
		stage_s2.last <= last_s1;
	end

	assign out_valid = vld_s2;
	assign out_stage = stage_s2;

endmodule

`default_nettype wire

// File: hw/rtl/r2p_iter.sv
// ----------------------------------------------------------------------------
// r2p_iter
// One chain stage: a CORDIC micro-rotation while STEP < CORDIC_STAGES and one digit of the square root while
// STEP < SAMPLE_BITS; otherwise that part of the state passes through.
`default_nettype none

module r2p_iter import r2p_pkg::*; #(
	parameter int STEP          = 0,
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire stage_t in_stage,
	output logic        out_valid,
	output stage_t      out_stage
);

	logic signed [XW-1:0]          x_n, y_n;
	logic signed [ZW-1:0]          z_n;
	logic        [RW-1:0]          rem_n;
	logic        [SAMPLE_BITS-1:0] root_n;
	logic                          vld_q;
	stage_t                        out_q;

	generate
		if (STEP < CORDIC_STAGES) begin : g_rot
			logic signed [XW-1:0] dx, dy;
			always_comb begin
				dx = in_stage.y >>> STEP;
				dy = in_stage.x >>> STEP;
				if (!in_stage.y[XW-1]) begin
					x_n = in_stage.x + dx;
					y_n = in_stage.y - dy;
					z_n = in_stage.z + atan_of(STEP);
				end else begin
					x_n = in_stage.x - dx;
					y_n = in_stage.y + dy;
					z_n = in_stage.z - atan_of(STEP);
				end
			end
		end else begin : g_rot_pass
			assign x_n = in_stage.x;
			assign y_n = in_stage.y;
			assign z_n = in_stage.z;
		end

		if (STEP < SAMPLE_BITS) begin : g_root
			logic [RW-1:0] rem_sh, trial;
			always_comb begin
				rem_sh = {in_stage.rem[SAMPLE_BITS-1:0], in_stage.s[SW-1-2*STEP -: 2]};
				trial  = {in_stage.root, 2'b01};
				if (rem_sh >= trial) begin
					rem_n  = rem_sh - trial;
					root_n = {in_stage.root[SAMPLE_BITS-2:0], 1'b1};
				end else begin
					rem_n  = rem_sh;
					root_n = {in_stage.root[SAMPLE_BITS-2:0], 1'b0};
				end
			end
		end else begin : g_root_pass
			assign rem_n  = in_stage.rem;
			assign root_n = in_stage.root;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_q.x    <= x_n;
		out_q.y    <= y_n;
		out_q.z    <= z_n;
		out_q.s    <= in_stage.s;
		out_q.rem  <= rem_n;
		out_q.root <= root_n;
		out_q.zero <= in_stage.zero;
		out_q.last <= in_stage.last;
	end

	assign out_valid = vld_q;
	assign out_stage = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/r2p_back.sv
// ----------------------------------------------------------------------------
// r2p_back
// Output stage: root rounding, angle rounding and clamp, zero-input override.
// ----------------------------------------------------------------------------
`default_nettype none

module r2p_back import r2p_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire stage_t in_stage,
	output logic        done,
	output rsp_t        result
);

	localparam logic signed [ZW-1:0] ANGLE_RND =
		(ANGLE_SHIFT == 0) ? '0 : ZW'(64'sd1 <<< (ANGLE_SHIFT - 1));
	localparam logic signed [ZW-1:0] ANGLE_HI =
		ZW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ZW-1:0] ANGLE_LO = -ANGLE_HI - ZW'(1);

	logic signed [ZW-1:0]          z_rnd, z_sh, z_clip;
	logic        [SAMPLE_BITS-1:0] mag_n;
	logic                          done_q;
	rsp_t                          result_q;

	always_comb begin
		z_rnd = in_stage.z + ANGLE_RND;
		z_sh  = z_rnd >>> ANGLE_SHIFT;
		if (z_sh > ANGLE_HI) begin
			z_clip = ANGLE_HI;
		end else if (z_sh < ANGLE_LO) begin
			z_clip = ANGLE_LO;
		end else begin
			z_clip = z_sh;
		end
		// round half up: bump when s - r^2 exceeds r
		if (in_stage.rem > {2'b00, in_stage.root}) begin
			mag_n = in_stage.root + 1'b1;
		end else begin
			mag_n = in_stage.root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.magnitude <= mag_n;
		result_q.angle     <= in_stage.zero ? '0 : z_clip[SAMPLE_BITS-1:0];
		result_q.last_out  <= in_stage.last;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/rect_to_polar_converter.sv
// ----------------------------------------------------------------------------
// rect_to_polar_converter
// Complex sample to magnitude and phase, fully pipelined CORDIC plus root.
// ----------------------------------------------------------------------------
// Usage: drive a request on req and raise start; the block takes one request
// every clock and busy stays low. Each result appears on result for exactly
// one cycle with done high. The receiver cannot stall the block and must
// take every done cycle. Two front stages form the squares, their sum and
// the quadrant fold; then comes the iteration chain, each stage of which does
// one CORDIC micro-rotation for the phase while its index is below
// CORDIC_STAGES and produces one bit of the integer square root for the
// magnitude while its index is below 16; one back stage rounds and clamps.
// magnitude is sqrt(re^2 + im^2) rounded half up; angle is atan2(im, re) with
// 32768 = pi, rounded and clamped to 32767 (so a phase of pi reads 32767).
// A zero input gives magnitude 0 and angle 0. last_in comes back as last_out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rect_to_polar_converter import r2p_pkg::*; #(
	parameter int CORDIC_STAGES = 16   // 8..24 micro-rotations
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      result
);

	// chain length covers both the rotations and the root digits
	localparam int CHAIN = (CORDIC_STAGES > SAMPLE_BITS) ? CORDIC_STAGES : SAMPLE_BITS;
	localparam int LAT   = CHAIN + 3;

	logic   chain_vld   [CHAIN+1];
	stage_t chain_stage [CHAIN+1];

	// no backpressure anywhere: a request is taken on every start
	assign busy = 1'b0;

	r2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.req       (req),
		.out_valid (chain_vld[0]),
		.out_stage (chain_stage[0])
	);

	genvar gi;
	generate
		for (gi = 0; gi < CHAIN; gi++) begin : g_chain
			r2p_iter #(
				.STEP          (gi),
				.CORDIC_STAGES (CORDIC_STAGES)
			) u_iter (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (chain_vld[gi]),
				.in_stage  (chain_stage[gi]),
				.out_valid (chain_vld[gi+1]),
				.out_stage (chain_stage[gi+1])
			);
		end
	endgenerate

	r2p_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_vld[CHAIN]),
		.in_stage (chain_stage[CHAIN]),
		.done     (done),
		.result   (result)
	);

	// every request comes out after a fixed latency, and only requests do
	`R2P_ASSERT(a_req_to_done, (start && !busy) |-> ##LAT done)
	`R2P_ASSERT(a_done_from_req, done |-> $past(start, LAT))
	`R2P_ASSERT(a_last_follows, done |-> (result.last_out == $past(req.last_in, LAT)))
	`R2P_ASSERT(a_zero_in_zero_out, (done && $past((req.real_part == '0) && (req.imag_part == '0), LAT)) |-> ((result.magnitude == '0) && (result.angle == '0)))
	`R2P_ASSERT_RST(a_quiet_in_reset, !arst_n |-> !done)

endmodule

`default_nettype wire

// File: sim/rect_to_polar_converter_tb.sv
// ----------------------------------------------------------------------------
// rect_to_polar_converter_tb
// Self-checking bench for the CORDIC rectangular-to-polar converter: a table
// of corner samples, then about a thousand random requests with random gaps,
// every result checked field by field against typed values or a bit-true software predictor.
// ----------------------------------------------------------------------------

module rect_to_polar_converter_tb;
	import r2p_pkg::*;

	localparam int STAGES        = 16;        // micro-rotations in the DUT
	localparam int FRAC_GUARD    = 24;        // guard bits on the x/y datapath
	localparam int RANDOM_COUNT  = 1030;
	localparam int DRAIN_CYCLES  = 40;        // longer than the pipeline depth
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PROBE_COUNT   = 22;

	// atan(2^-k), scaled so that 2^31 is pi
	localparam longint ATAN_STEP [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// one row of the corner table; fixed = 1 means mag/ang are typed in
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          last;
		logic                          fixed;
		logic        [SAMPLE_BITS-1:0] mag;
		logic signed [SAMPLE_BITS-1:0] ang;
	} probe_row_t;

	// Corner samples. Typed rows: zero input, the phase-of-pi clamp, the full
	// scale axes and the far diagonal; everything else goes to the predictor.
	localparam probe_row_t PROBES [PROBE_COUNT] = '{
		'{16'sd0,      16'sd0,      1'b0, 1'b1, 16'd0,     16'sd0},       // zero
		'{16'sd0,      16'sd0,      1'b1, 1'b1, 16'd0,     16'sd0},       // zero, last
		'{16'sd32767,  16'sd0,      1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'h8000,    16'sd0,      1'b1, 1'b1, 16'd32768, 16'sd32767},   // pi clamps
		'{16'sd0,      16'sd32767,  1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'sd0,      16'h8000,    1'b0, 1'b1, 16'd32768, -16'sd16384},  // -pi/2
		'{16'sd32767,  16'sd32767,  1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'h8000,    16'h8000,    1'b0, 1'b1, 16'd46341, -16'sd24576},  // max length
		'{16'sd32767,  16'h8000,    1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'h8000,    16'sd32767,  1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'sd1,      16'sd0,      1'b0, 1'b0, 16'd0,     16'sd0},
		'{-16'sd1,     16'sd0,      1'b0, 1'b1, 16'd1,     16'sd32767},   // tiny pi
		'{16'sd0,      16'sd1,      1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'sd0,      -16'sd1,     1'b0, 1'b0, 16'd0,     16'sd0},
		'{-16'sd1,     -16'sd1,     1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'h8000,    16'sd1,      1'b0, 1'b0, 16'd0,     16'sd0},       // just under pi
		'{16'h8000,    -16'sd1,     1'b0, 1'b0, 16'd0,     16'sd0},       // just over -pi
		'{16'h5555,    16'hAAAA,    1'b1, 1'b0, 16'd0,     16'sd0},
		'{16'hAAAA,    16'h5555,    1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'sd3,      16'sd4,      1'b0, 1'b0, 16'd0,     16'sd0},
		'{-16'sd3,     -16'sd4,     1'b0, 1'b0, 16'd0,     16'sd0},
		'{16'sd100,    -16'sd100,   1'b1, 1'b0, 16'd0,     16'sd0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b1;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t result;

	// DUT outputs as seen in the middle of each cycle
	logic busy_s;
	logic done_s;
	rsp_t result_s;

	rsp_t expected_polars [$];
	int   request_count = 0;
	int   result_count  = 0;
	int   error_count   = 0;
	int   pi_clamps     = 0;
	int   cycle_count   = 0;
	int   burst_left    = 0;

	rect_to_polar_converter #(.CORDIC_STAGES(STAGES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample at the falling edge: inputs only move at the rising edge, so the
	// values here are settled and free of any ordering race.
	always @(negedge clk) begin
		busy_s   <= busy;
		done_s   <= done;
		result_s <= result;
	end

	// Bit-true polar conversion of one request.
	// Magnitude: exact integer root, rounded half up.
	// Angle: quadrant fold, then STAGES vectoring micro-rotations with 24
	// guard bits; accumulator has 2^31 = pi, rounded to 16 bits and clamped.
	function automatic rsp_t expected_polar(input req_t r);
		longint re, im, x, y, z, t, dx, dy, ang;
		longint unsigned sq, root, rem, b;
		rsp_t o;
		re = longint'(r.real_part);
		im = longint'(r.imag_part);
		o = '0;
		o.last_out = r.last_in;
		if (re == 0 && im == 0)
			return o;

		sq   = longint'(re * re + im * im);
		root = 0;
		rem  = sq;
		b    = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (sq > root * root + root)
			root = root + 1;
		o.magnitude = root[SAMPLE_BITS-1:0];

		x = re <<< FRAC_GUARD;
		y = im <<< FRAC_GUARD;
		z = 0;
		// left half-plane: rotate by a quarter turn first
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y;  y = -t; z = 64'sd1 <<< 30;
			end else begin
				t = x; x = -y; y = t;  z = -(64'sd1 <<< 30);
			end
		end
		for (int k = 0; k < STAGES && k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + ATAN_STEP[k];
			end else begin
				x = x - dx; y = y + dy; z = z - ATAN_STEP[k];
			end
		end
		ang = (z + 64'sd32768) >>> 16;
		if (ang > 32767)
			ang = 32767;
		if (ang < -32768)
			ang = -32768;
		o.angle = ang[SAMPLE_BITS-1:0];
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Present one request after 'gap' idle cycles and hold it until taken.
	// start stays high across back-to-back requests (no drop and re-raise).
	task automatic issue_request(input req_t r, input rsp_t want, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy_s !== 1'b0);
		expected_polars.push_back(want);
		request_count++;
		if (want.angle == 16'sd32767)
			pi_clamps++;
	endtask

	// Sender idle draw: mostly a uniform random gap, with back-to-back bursts mixed in
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			burst_left = int'($urandom_range(10, 60));
		return int'($urandom_range(0, 10));
	endfunction

	// Random component: mostly full range, with small values, axes, extremes
	// and diagonals mixed in so that every quadrant boundary gets traffic.
	function automatic req_t random_request();
		req_t r;
		logic signed [SAMPLE_BITS-1:0] pick [6];
		int kind;
		pick = '{16'h8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		kind = int'($urandom_range(0, 9));
		r.real_part = SAMPLE_BITS'($urandom());
		r.imag_part = SAMPLE_BITS'($urandom());
		r.last_in   = ($urandom_range(0, 7) == 0);
		case (kind)
			6: begin
				r.real_part = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
				r.imag_part = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
			end
			7: begin
				if ($urandom_range(0, 1))
					r.real_part = '0;
				else
					r.imag_part = '0;
			end
			8: begin
				r.real_part = pick[$urandom_range(0, 5)];
				r.imag_part = pick[$urandom_range(0, 5)];
			end
			9: r.imag_part = $urandom_range(0, 1) ? r.real_part : -r.real_part;
			default: ;
		endcase
		return r;
	endfunction

	// Result checker: every done cycle must match the oldest outstanding request
	always @(posedge clk) begin
		rsp_t want;
		if (done_s === 1'b1) begin
			result_count++;
			if (expected_polars.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request outstanding",
					result_count));
			end else begin
				want = expected_polars.pop_front();
				if (result_s.magnitude !== want.magnitude)
					report_mismatch($sformatf("result %0d magnitude %0d, want %0d",
						result_count, result_s.magnitude, want.magnitude));
				if (result_s.angle !== want.angle)
					report_mismatch($sformatf("result %0d angle %0d, want %0d",
						result_count, $signed(result_s.angle), $signed(want.angle)));
				if (result_s.last_out !== want.last_out)
					report_mismatch($sformatf("result %0d last_out %b, want %b",
						result_count, result_s.last_out, want.last_out));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_polars.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		req_t r;
		rsp_t want;
		// falling edge on reset so the asynchronous clears take effect at once
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner table
		for (int i = 0; i < PROBE_COUNT; i++) begin
			r.real_part = PROBES[i].re;
			r.imag_part = PROBES[i].im;
			r.last_in   = PROBES[i].last;
			if (PROBES[i].fixed) begin
				want.magnitude = PROBES[i].mag;
				want.angle     = PROBES[i].ang;
				want.last_out  = PROBES[i].last;
			end else begin
				want = expected_polar(r);
			end
			issue_request(r, want, next_gap());
		end

		// random traffic
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			r = random_request();
			issue_request(r, expected_polar(r), next_gap());
		end
		start <= 1'b0;

		while (expected_polars.size() != 0)
			@(posedge clk);
		// catch any stray extra results
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d samples (%0d corner cases), %0d results checked,",
			request_count, PROBE_COUNT, result_count);
		$display("  %0d of them on the +pi clamp; %0d mismatches", pi_clamps, error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/r2p_pkg.sv
hw/rtl/r2p_front.sv
hw/rtl/r2p_iter.sv
hw/rtl/r2p_back.sv
hw/rtl/rect_to_polar_converter.sv
sim/rect_to_polar_converter_tb.sv
